/* src/rldf_pkg.sv */
// Package for the ring line direction finder.
// Holds sizes, lane count and the result struct; no dependencies.
package rldf_pkg;
    localparam int SensorCount = 32;
    localparam int IdxW = 5;
    localparam int LaneCount = 4;
    localparam int LaneSelW = 2;
    localparam int SpanW = 5;
    localparam int BisW = 6;

    typedef struct packed {
        logic             found;
        logic [IdxW-1:0]  start_index;
        logic [IdxW-1:0]  end_index;
        logic [BisW-1:0]  bisector_half_steps;
        logic [SpanW-1:0] span_steps;
    } t_result;
endpackage

/* src/rldf_if.sv */
// Valid/ready channel interfaces for the ring line direction finder.
// Depends on rldf_pkg.
interface rldf_in_if import rldf_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [31:0] pass_mask;
    modport source (output valid, output pass_mask, input ready);
    modport sink   (input valid, input pass_mask, output ready);
endinterface

interface rldf_out_if import rldf_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/ring_line_direction_finder.sv */
// Top level of the ring line direction finder.
// Depends on rldf_pkg, rldf_if and rldf_lane.
//
// Usage: one pass_mask per input transfer on i_in; one result per item on
// o_out. Four lanes each own start indices i = lane, lane+4, ...; every cycle
// every lane tests one partner j. A scan walks 8 row steps x 32 columns, then
// the merge state picks the earliest best over lanes (lowest i wins ties,
// matching scan order). All lanes step through one shared row/column counter.
// The input is not ready while a scan or merge runs. The result sits in an
// output register; i_in is ready again once the result is out or while it
// waits (a new scan may start; it only stalls at merge until o_out is taken).
// Reset (synchronous, active low) empties the block and holds i_in not ready;
// nothing is in flight afterward.
module ring_line_direction_finder import rldf_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    rldf_in_if.sink    i_in,
    rldf_out_if.source o_out
);
    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_MERGE = 3'b100
    } t_state;

    t_state  r_state, n_state;
    logic [31:0] r_mask;
    logic [IdxW-LaneSelW-1:0] r_row;
    logic [IdxW-1:0] r_col;
    logic    r_ovalid;
    t_result r_res, n_res;
    t_result lane_best [LaneCount];

    wire start = i_in.valid && i_in.ready;
    wire scan_last = (r_state == ST_SCAN) && (r_row == '1) && (r_col == '1);
    wire merge_go = (r_state == ST_MERGE) && (!r_ovalid || o_out.ready);

    assign i_in.ready = (r_state == ST_IDLE) && i_rst_n;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_res;

    for (genvar g = 0; g < LaneCount; g++) begin : g_lane
        rldf_lane u_lane (
            .i_clk  (i_clk),
            .i_start(start),
            .i_en   (r_state == ST_SCAN),
            .i_mask (r_mask),
            .i_i    ({r_row, LaneSelW'(g)}),
            .i_j    (r_col),
            .o_best (lane_best[g])
        );
    end

    // Merge: strictly greater span replaces; lanes compared by lowest i.
    always_comb begin
        n_res = lane_best[0];
        for (int k = 1; k < LaneCount; k++) begin
            if (lane_best[k].found && (!n_res.found ||
                lane_best[k].span_steps > n_res.span_steps ||
                (lane_best[k].span_steps == n_res.span_steps &&
                 lane_best[k].start_index < n_res.start_index))) begin
                n_res = lane_best[k];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_SCAN;
            ST_SCAN:  if (scan_last) n_state = ST_MERGE;
            ST_MERGE: if (merge_go) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_row    <= '0;
            r_col    <= '0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_row <= '0;
                r_col <= '0;
            end else if (r_state == ST_SCAN) begin
                r_col <= r_col + 1'b1;
                if (r_col == '1) r_row <= r_row + 1'b1;
            end
            if (merge_go) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) r_mask <= i_in.pass_mask;
        if (merge_go) r_res <= n_res;
    end

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !i_in.ready) else $error("accept while busy");
    a_scan_to_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_last |=> (r_state == ST_MERGE)) else $error("scan end lost");
    a_result_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.data.found) |->
        (o_out.data.end_index > o_out.data.start_index)) else $error("bad pair");
endmodule

/* src/rldf_lane.sv */
// One lane: scans partner j for each start i it owns, keeps best pair of its own.
// Depends on rldf_pkg.
module rldf_lane import rldf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_start,   // clear lane best
    input  logic            i_en,      // evaluate pair (i,j)
    input  logic [31:0]     i_mask,
    input  logic [IdxW-1:0] i_i,
    input  logic [IdxW-1:0] i_j,
    output t_result         o_best
);
    logic [IdxW:0]  d, other;
    logic [SpanW-1:0] span;
    logic [BisW:0]  bis;
    logic           hit;
    t_result        r_best;

    always_comb begin
        d     = {1'b0, i_j} - {1'b0, i_i};
        other = (IdxW+1)'(SensorCount) - d;
        span  = (d <= other) ? SpanW'(d) : SpanW'(other);
        bis   = {2'b0, i_i} + {2'b0, i_j} + ((d <= other) ? 7'd0 : 7'(SensorCount));
        hit   = i_en && (i_j > i_i) && i_mask[i_i] && i_mask[i_j] &&
                (!r_best.found || span > r_best.span_steps);
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_best <= '0;
        end else if (hit) begin
            r_best <= '{1'b1, i_i, i_j, bis[BisW-1:0], span};
        end
    end

    assign o_best = r_best;
endmodule
